/* hdl/tti_pkg.sv */
package tti_pkg;

  localparam int MaxRows  = 256;
  localparam int MaxAxis  = 16;
  localparam int FracBits = 16;
  localparam int RowW     = $clog2(MaxRows);
  localparam int AxW      = $clog2(MaxAxis);
  localparam logic [31:0] FailReset = 32'd65536000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [31:0] gas;
    logic [31:0] oil;
    logic [31:0] water;
    logic [31:0] drop;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LCHK, S_LROW, S_INS, S_QCHK, S_LOC, S_DIV, S_CSET, S_CRD, S_CCMP,
    S_CDROP, S_CWAIT, S_LERP, S_LMUL, S_DONE
  } state_t;

endpackage

/* hdl/trilinear_table_interpolator.sv */
// channel  direction  ports                                    handshake
// in       input      in_operation in_rate_* in_drop_value     push / full
// out      output     out_result_value out_status              empty / pop
// cfg      input      cfg_fail_value                           cfg_we
//
// a load checks the table, writes the row and inserts its axis values; a query runs
// the bit-serial divider once per axis, then 8 corner scans of up to all rows through
// the row memories, then the lerp
// reset clears row count, axis lengths and queues; row memories need no clearing
// a two-beat input queue keeps accepting, until full, while the engine works or waits on pop
module trilinear_table_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [31:0] in_rate_gas,
  input  logic [31:0] in_rate_oil,
  input  logic [31:0] in_rate_water,
  input  logic [31:0] in_drop_value,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_result_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_fail_value
);
  tti_pkg::item_t din, q_item;
  logic q_avail, q_take, r_valid;
  logic [31:0] fail_r;

  // fail value register
  always_ff @(posedge clk) begin
    if (!rst_n) fail_r <= tti_pkg::FailReset;
    else if (cfg_we) fail_r <= cfg_fail_value;
  end

  assign din = '{op: in_operation, gas: in_rate_gas, oil: in_rate_oil,
                 water: in_rate_water, drop: in_drop_value};

  tti_front u_front (.clk, .rst_n, .push, .din, .full, .avail(q_avail),
    .dout(q_item), .take(q_take));

  tti_back u_back (.clk, .rst_n, .avail(q_avail), .item(q_item), .take(q_take),
    .fail_value(fail_r), .res_valid(r_valid), .res_value(out_result_value),
    .res_status(out_status), .res_ready(pop));

  assign empty = !r_valid;
endmodule

/* hdl/tti_ram.sv */
module tti_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/tti_front.sv */
// input queue: two-entry fifo between the accept side and the engine
module tti_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tti_pkg::item_t din,
  output logic           full,
  output logic           avail,
  output tti_pkg::item_t dout,
  input  logic           take
);
  tti_pkg::item_t q_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic do_push, do_take;

  assign full    = cnt_r == 2'd2;
  assign avail   = cnt_r != 2'd0;
  assign dout    = q_r[rd_r];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= din;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_take};
    end
  end
endmodule

/* hdl/tti_div.sv */
// restoring divider, one quotient bit a cycle: (num << FracBits) / den
module tti_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  localparam int NW = 32 + tti_pkg::FracBits;
  logic [NW-1:0] n_r;
  logic [32:0]   rem_r;
  logic [31:0]   d_r;
  logic [NW-1:0] q_r;
  logic [6:0]    cnt_r;
  logic [33:0]   trial;

  assign busy  = cnt_r != 7'd0;
  assign quo   = q_r[31:0];
  assign trial = {rem_r, n_r[NW-1]} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else if (start) begin
      n_r   <= {num, {tti_pkg::FracBits{1'b0}}};
      d_r   <= den;
      rem_r <= 33'd0;
      cnt_r <= 7'(NW);
    end else if (busy) begin
      if (!trial[33]) rem_r <= trial[32:0];
      else rem_r <= {rem_r[31:0], n_r[NW-1]};
      q_r   <= {q_r[NW-2:0], ~trial[33]};
      n_r   <= n_r << 1;
      cnt_r <= cnt_r - 7'd1;
    end
  end
endmodule

/* hdl/tti_back.sv */
// execution engine: loads, axis upkeep, locate, divide, corner search, lerp
module tti_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           avail,
  input  tti_pkg::item_t item,
  output logic           take,
  input  logic [31:0]    fail_value,
  output logic           res_valid,
  output logic [31:0]    res_value,
  output logic [1:0]     res_status,
  input  logic           res_ready
);
  localparam int RW = tti_pkg::RowW;
  localparam int AW = tti_pkg::AxW;
  localparam int FB = tti_pkg::FracBits;

  tti_pkg::state_t st_r, st_nxt;
  tti_pkg::item_t  it_r;
  logic [31:0] ax_r [3][tti_pkg::MaxAxis];
  logic [AW:0] alen_r [3];
  logic [RW:0] rows_r;
  logic [31:0] rate [3];
  logic        has [3];
  logic [AW-1:0] up_i [3];
  logic [AW-1:0] lo_r [3], hi_r [3];
  logic [31:0] frac_r [3];
  logic [1:0]  ax_sel_r;
  logic [2:0]  cor_r;
  logic [RW:0] scan_r;
  logic [RW-1:0] hit_r;
  logic        found_r;
  logic signed [31:0] drop_r [8];
  logic signed [31:0] lv_r [8];
  logic [2:0]  lstep_r;
  logic signed [31:0] la, lb;
  logic signed [63:0] pa_r, pb_r;
  logic [31:0] lf;
  logic [31:0] out_v_r;
  logic [1:0]  out_s_r;
  logic        out_vld_r;
  logic        wr_row;
  logic [RW-1:0] raddr;
  logic [31:0] rd_g, rd_o, rd_w, rd_d;
  logic        div_start, div_busy;
  logic [31:0] div_q, cg, co, cw;
  logic        in_rng;
  logic        rfull;

  assign rate[0] = it_r.gas;
  assign rate[1] = it_r.oil;
  assign rate[2] = it_r.water;

  // membership search (sixteen compares per axis) and interval search (fifteen compares per axis)
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      has[a]  = 1'b0;
      up_i[a] = AW'(alen_r[a] - 1'b1);
      for (int i = tti_pkg::MaxAxis - 1; i >= 1; i--) begin
        if ((AW+1)'(i) < alen_r[a] && ax_r[a][i] > rate[a]) up_i[a] = AW'(i);
      end
      for (int i = 0; i < tti_pkg::MaxAxis; i++) begin
        if ((AW+1)'(i) < alen_r[a] && ax_r[a][i] == rate[a]) has[a] = 1'b1;
      end
    end
  end

  always_comb begin
    in_rng = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (rate[a] < ax_r[a][0] || rate[a] > ax_r[a][AW'(alen_r[a] - 1'b1)]) in_rng = 1'b0;
    end
  end

  assign rfull = rows_r == (RW+1)'(tti_pkg::MaxRows);
  assign wr_row = st_r == tti_pkg::S_LROW;
  assign raddr  = scan_r[RW-1:0];
  assign cg = ax_r[0][cor_r[0] ? hi_r[0] : lo_r[0]];
  assign co = ax_r[1][cor_r[1] ? hi_r[1] : lo_r[1]];
  assign cw = ax_r[2][cor_r[2] ? hi_r[2] : lo_r[2]];

  tti_ram #(.Width(32), .Depth(tti_pkg::MaxRows)) u_g (.clk, .we(wr_row),
    .waddr(rows_r[RW-1:0]), .wdata(it_r.gas), .raddr, .rdata(rd_g));
  tti_ram #(.Width(32), .Depth(tti_pkg::MaxRows)) u_o (.clk, .we(wr_row),
    .waddr(rows_r[RW-1:0]), .wdata(it_r.oil), .raddr, .rdata(rd_o));
  tti_ram #(.Width(32), .Depth(tti_pkg::MaxRows)) u_w (.clk, .we(wr_row),
    .waddr(rows_r[RW-1:0]), .wdata(it_r.water), .raddr, .rdata(rd_w));
  tti_ram #(.Width(32), .Depth(tti_pkg::MaxRows)) u_d (.clk, .we(wr_row),
    .waddr(rows_r[RW-1:0]), .wdata(it_r.drop), .raddr, .rdata(rd_d));

  assign div_start = st_r == tti_pkg::S_LOC && alen_r[ax_sel_r] >= (AW+1)'(2);
  tti_div u_div (.clk, .rst_n, .start(div_start),
    .num(rate[ax_sel_r] - ax_r[ax_sel_r][AW'(up_i[ax_sel_r] - 1'b1)]),
    .den(ax_r[ax_sel_r][up_i[ax_sel_r]] - ax_r[ax_sel_r][AW'(up_i[ax_sel_r] - 1'b1)]),
    .busy(div_busy), .quo(div_q));

  // lerp schedule: steps 0..3 along gas, 4..5 oil, 6 water
  always_comb begin
    case (lstep_r)
      3'd0: begin la = drop_r[0]; lb = drop_r[1]; lf = frac_r[0]; end
      3'd1: begin la = drop_r[2]; lb = drop_r[3]; lf = frac_r[0]; end
      3'd2: begin la = drop_r[4]; lb = drop_r[5]; lf = frac_r[0]; end
      3'd3: begin la = drop_r[6]; lb = drop_r[7]; lf = frac_r[0]; end
      3'd4: begin la = lv_r[0];   lb = lv_r[1];   lf = frac_r[1]; end
      3'd5: begin la = lv_r[2];   lb = lv_r[3];   lf = frac_r[1]; end
      3'd6: begin la = lv_r[4];   lb = lv_r[5];   lf = frac_r[2]; end
      default: begin la = '0; lb = '0; lf = '0; end
    endcase
  end

  logic signed [63:0] lsum;
  assign lsum = pa_r + pb_r + (64'sd1 <<< (FB - 1));

  assign take       = st_r == tti_pkg::S_IDLE && avail && !out_vld_r;
  assign res_valid  = out_vld_r;
  assign res_value  = out_v_r;
  assign res_status = out_s_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tti_pkg::S_IDLE:  if (take) st_nxt = item.op ? tti_pkg::S_QCHK : tti_pkg::S_LCHK;
      tti_pkg::S_LCHK: begin
        if (rfull || (alen_r[0][AW] && !has[0]) || (alen_r[1][AW] && !has[1]) ||
            (alen_r[2][AW] && !has[2])) st_nxt = tti_pkg::S_DONE;
        else st_nxt = tti_pkg::S_LROW;
      end
      tti_pkg::S_LROW:  st_nxt = tti_pkg::S_INS;
      tti_pkg::S_INS:   st_nxt = tti_pkg::S_DONE;
      tti_pkg::S_QCHK: begin
        if (rows_r == '0 || alen_r[0] == '0 || alen_r[1] == '0 || alen_r[2] == '0 || !in_rng)
          st_nxt = tti_pkg::S_DONE;
        else st_nxt = tti_pkg::S_LOC;
      end
      tti_pkg::S_LOC:   st_nxt = tti_pkg::S_DIV;
      tti_pkg::S_DIV: if (!div_busy) begin
        st_nxt = (ax_sel_r == 2'd2) ? tti_pkg::S_CSET : tti_pkg::S_LOC;
      end
      tti_pkg::S_CSET:  st_nxt = tti_pkg::S_CRD;
      tti_pkg::S_CRD:   st_nxt = tti_pkg::S_CCMP;
      tti_pkg::S_CCMP: begin
        if ((rd_g == cg && rd_o == co && rd_w == cw) || scan_r + 1'b1 >= rows_r)
          st_nxt = tti_pkg::S_CDROP;
        else st_nxt = tti_pkg::S_CRD;
      end
      tti_pkg::S_CDROP: st_nxt = tti_pkg::S_CWAIT;
      tti_pkg::S_CWAIT: st_nxt = (cor_r == 3'd7) ? tti_pkg::S_LMUL : tti_pkg::S_CSET;
      tti_pkg::S_LMUL:  st_nxt = tti_pkg::S_LERP;
      tti_pkg::S_LERP:  st_nxt = (lstep_r == 3'd6) ? tti_pkg::S_DONE : tti_pkg::S_LMUL;
      tti_pkg::S_DONE:  st_nxt = tti_pkg::S_IDLE;
      default:          st_nxt = tti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tti_pkg::S_IDLE;
      out_vld_r <= 1'b0;
      rows_r    <= '0;
      for (int a = 0; a < 3; a++) alen_r[a] <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_valid && res_ready) out_vld_r <= 1'b0;
      case (st_r)
        tti_pkg::S_IDLE: if (take) begin
          it_r <= item; ax_sel_r <= 2'd0;
        end
        tti_pkg::S_LCHK: begin
          out_v_r <= '0;
          out_s_r <= (st_nxt == tti_pkg::S_LROW) ? tti_pkg::ST_OK : tti_pkg::ST_FULL;
        end
        tti_pkg::S_LROW: rows_r <= rows_r + 1'b1;
        tti_pkg::S_INS: begin
          // sorted insert: entries above the new value move up one
          for (int a = 0; a < 3; a++) begin
            if (!has[a]) begin
              for (int i = 0; i < tti_pkg::MaxAxis; i++) begin
                if ((AW+1)'(i) <= alen_r[a]) begin
                  if (i > 0 && ax_r[a][AW'(i - 1)] > rate[a]) ax_r[a][i] <= ax_r[a][AW'(i - 1)];
                  else if (i == 0 || ax_r[a][AW'(i - 1)] < rate[a]) begin
                    if ((AW+1)'(i) == alen_r[a] || ax_r[a][i] > rate[a]) ax_r[a][i] <= rate[a];
                  end
                end
              end
              alen_r[a] <= alen_r[a] + 1'b1;
            end
          end
        end
        tti_pkg::S_QCHK: begin
          out_v_r <= fail_value;
          out_s_r <= (rows_r == '0 || alen_r[0] == '0 || alen_r[1] == '0 ||
                      alen_r[2] == '0) ? tti_pkg::ST_EMPTY : tti_pkg::ST_RANGE;
        end
        tti_pkg::S_LOC: begin
          if (alen_r[ax_sel_r] < (AW+1)'(2)) begin
            lo_r[ax_sel_r] <= '0; hi_r[ax_sel_r] <= '0;
          end else begin
            lo_r[ax_sel_r] <= AW'(up_i[ax_sel_r] - 1'b1); hi_r[ax_sel_r] <= up_i[ax_sel_r];
          end
        end
        tti_pkg::S_DIV: if (!div_busy) begin
          frac_r[ax_sel_r] <= (alen_r[ax_sel_r] < (AW+1)'(2)) ? 32'd0 : div_q;
          ax_sel_r <= ax_sel_r + 2'd1;
          cor_r    <= 3'd0;
        end
        tti_pkg::S_CSET:  begin scan_r <= '0; found_r <= 1'b0; hit_r <= '0; end
        tti_pkg::S_CCMP: begin
          if (rd_g == cg && rd_o == co && rd_w == cw) begin
            found_r <= 1'b1; hit_r <= scan_r[RW-1:0];
          end else if (scan_r + 1'b1 < rows_r) scan_r <= scan_r + 1'b1;
          else scan_r <= '0;   // no match: row 0 is read next
        end
        tti_pkg::S_CDROP: scan_r <= found_r ? {1'b0, hit_r} : '0;
        tti_pkg::S_CWAIT: begin
          drop_r[cor_r] <= rd_d;
          cor_r         <= cor_r + 3'd1;
          lstep_r       <= 3'd0;
        end
        tti_pkg::S_LMUL: begin
          pa_r <= la * $signed({1'b0, 32'((33'd1 << FB) - {1'b0, lf})});
          pb_r <= lb * $signed({1'b0, lf});
        end
        tti_pkg::S_LERP: begin
          lv_r[lstep_r] <= 32'(lsum >>> FB);
          out_v_r       <= 32'(lsum >>> FB);
          out_s_r       <= tti_pkg::ST_OK;
          lstep_r       <= lstep_r + 3'd1;
        end
        tti_pkg::S_DONE: out_vld_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
